/* sv/gmpq_pkg.sv */
// ----------------------------------------------------------------------------
// gmpq_pkg: shared types and constants for the gap model position query unit
// Holds the table size, field widths, request and status codes, the word that
// travels along the cell chain, and the result word.
// ----------------------------------------------------------------------------
package gmpq_pkg;

  // Table size and derived widths
  localparam int MAX_RUNS = 16;
  localparam int POS_W    = 31;
  localparam int END_W    = POS_W + 1;
  localparam int ROW_W    = 32;
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int SUM_W    = POS_W + CNT_W;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ORDER  = 2'd2,
    ST_ANSWER = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_HOLD = 2'd2
  } state_t;

  // Query word handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             allow;
    logic             hit;
    logic             after;
    logic             front;
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] gsum;
  } msg_t;

  // Result word
  typedef struct packed {
    status_t          status;
    logic             is_gap;
    logic             is_edge_gap;
    logic [POS_W-1:0] ungapped_pos;
    logic             pos_valid;
    logic [ROW_W-1:0] row_length;
  } result_t;

endpackage

/* sv/gap_model_position_query_unit.sv */
// ----------------------------------------------------------------------------
// gap_model_position_query_unit: gap table of one alignment row
// Keeps sorted gap runs in a chain of cells and answers column queries.
//
//   channel  | handshake            | word
//   ---------+----------------------+---------------------------------------
//   request  | req_valid/req_stall  | req_type gap_start gap_length
//            |                      | query_pos allow_gap
//   response | rsp_valid/rsp_stall  | status is_gap is_edge_gap
//            |                      | ungapped_pos pos_valid row_length
//   config   | cfg_wr_en            | cfg_wr_data (data_length)
//
// A clear or append waits in S_HOLD until the response register is free before the
// next request is taken. A query's word walks the chain one cell per cycle, then
// the answer is resolved and moved to the response register.
// A request is taken while an earlier response still waits on rsp_stall.
// Reset empties the table and the response register; run storage is not
// cleared, only cells below the run count take part in a query.
// ----------------------------------------------------------------------------
module gap_model_position_query_unit
  import gmpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [POS_W-1:0] cfg_wr_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [1:0]       req_type,
  input  logic [POS_W-1:0] gap_start,
  input  logic [POS_W-1:0] gap_length,
  input  logic [POS_W-1:0] query_pos,
  input  logic             allow_gap,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [1:0]       status,
  output logic             is_gap,
  output logic             is_edge_gap,
  output logic [POS_W-1:0] ungapped_pos,
  output logic             pos_valid,
  output logic [ROW_W-1:0] row_length
);

  state_t           state, state_next;
  logic [POS_W-1:0] data_length;
  logic [CNT_W-1:0] run_count;
  logic [ROW_W-1:0] total_gap;
  logic [END_W-1:0] last_end;
  msg_t             head;
  msg_t             chain [0:MAX_RUNS];
  logic [MAX_RUNS-1:0] cell_wr;
  logic [MAX_RUNS-1:0] cell_used;
  result_t          res;
  result_t          rsp;
  result_t          query_res;
  result_t          plain_res;

  req_t             req;
  logic             accept;
  logic             out_free;
  logic             load_rsp;
  logic             take_query;
  logic             append_ok;
  status_t          append_status;
  logic [ROW_W:0]   gap_sum;

  assign req      = req_t'(req_type);
  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req == REQ_QUERY) ? S_RUN : S_HOLD;
        end
      end
      S_RUN: begin
        if (chain[MAX_RUNS].valid) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_stall  = 1'b1;
    take_query = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      S_IDLE:  req_stall  = 1'b0;
      S_RUN:   take_query = chain[MAX_RUNS].valid;
      S_HOLD:  load_rsp   = out_free;
      default: req_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the data length register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= '0;
    end else if (cfg_wr_en) begin
      data_length <= cfg_wr_data;
    end
  end

  // Check an append against the table
  always_comb begin
    append_ok     = 1'b0;
    append_status = ST_DONE;
    gap_sum       = {1'b0, total_gap} + {2'b00, gap_length};
    priority if (run_count == CNT_W'(MAX_RUNS)) begin
      append_status = ST_FULL;
    end else if ((gap_length == '0) ||
                 ((run_count != '0) && ({1'b0, gap_start} < last_end))) begin
      append_status = ST_ORDER;
    end else begin
      append_ok = accept && (req == REQ_APPEND);
    end
  end

  // Result of clear, append and unknown requests
  always_comb begin
    plain_res = '0;
    unique case (req)
      REQ_APPEND: plain_res.status = append_status;
      default:    plain_res.status = ST_DONE;
    endcase
  end

  // Update the table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      total_gap <= '0;
    end else if (accept && (req == REQ_CLEAR)) begin
      run_count <= '0;
      total_gap <= '0;
    end else if (append_ok) begin
      run_count <= run_count + CNT_W'(1);
      total_gap <= gap_sum[ROW_W] ? {ROW_W{1'b1}} : gap_sum[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      last_end <= {1'b0, gap_start} + {1'b0, gap_length};
    end
  end

  // Launch a query into the chain; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept && (req == REQ_QUERY);
    end
    head.first <= 1'b1;
    head.allow <= allow_gap;
    head.hit   <= 1'b0;
    head.after <= 1'b0;
    head.front <= 1'b0;
    head.pos   <= query_pos;
    head.gsum  <= '0;
  end

  assign chain[0] = head;

  // Row of run cells
  for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
    assign cell_wr[i]   = append_ok && (run_count == CNT_W'(i));
    assign cell_used[i] = CNT_W'(i) < run_count;

    gmpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (cell_wr[i]),
      .wr_start  (gap_start),
      .wr_length (gap_length),
      .used      (cell_used[i]),
      .msg_in    (chain[i]),
      .msg_out   (chain[i+1])
    );
  end

  gmpq_resolve u_resolve (
    .msg         (chain[MAX_RUNS]),
    .data_length (data_length),
    .total_gap   (total_gap),
    .table_used  (run_count != '0),
    .res         (query_res)
  );

  // Hold the finished result until the response register frees
  always_ff @(posedge clk) begin
    if (accept && (req != REQ_QUERY)) begin
      res <= plain_res;
    end else if (take_query) begin
      res <= query_res;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= res;
    end
  end

  assign status       = rsp.status;
  assign is_gap       = rsp.is_gap;
  assign is_edge_gap  = rsp.is_edge_gap;
  assign ungapped_pos = rsp.ungapped_pos;
  assign pos_valid    = rsp.pos_valid;
  assign row_length   = rsp.row_length;

endmodule

/* sv/gmpq_cell.sv */
// ----------------------------------------------------------------------------
// gmpq_cell: one gap run of the table
// Stores one run and updates the query word passing through it: hit inside
// the run, run beyond the column, leading gap at the first run, and the count
// of gap columns before the column.
// ----------------------------------------------------------------------------
module gmpq_cell
  import gmpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [POS_W-1:0] wr_start,
  input  logic [POS_W-1:0] wr_length,
  input  logic             used,
  input  msg_t             msg_in,
  output msg_t             msg_out
);

  logic [POS_W-1:0] run_start;
  logic [POS_W-1:0] run_length;
  logic [END_W-1:0] run_end;

  logic [END_W-1:0] pos_ext;
  logic             active;
  logic             start_lt_pos;
  logic             end_gt_pos;
  logic [POS_W-1:0] part;
  msg_t             msg_next;

  // Store the run, with its end worked out once at write time
  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_start  <= wr_start;
      run_length <= wr_length;
      run_end    <= {1'b0, wr_start} + {1'b0, wr_length};
    end
  end

  // Compare the column against this run and add its gap columns
  always_comb begin
    pos_ext      = {1'b0, msg_in.pos};
    active       = msg_in.valid && used;
    start_lt_pos = run_start < msg_in.pos;
    end_gt_pos   = run_end > pos_ext;
    if (msg_in.allow && end_gt_pos) begin
      part = msg_in.pos - run_start;
    end else begin
      part = run_length;
    end
    msg_next       = msg_in;
    msg_next.first = 1'b0;
    if (active) begin
      if (!start_lt_pos && (run_start != msg_in.pos)) begin
        msg_next.after = 1'b1;
      end
      if (!(msg_in.pos < run_start) && end_gt_pos) begin
        msg_next.hit = 1'b1;
      end
      if (msg_in.first) begin
        msg_next.front = (run_start == '0) && (msg_in.pos < run_length);
      end
      if (start_lt_pos) begin
        msg_next.gsum = msg_in.gsum + {{(SUM_W-POS_W){1'b0}}, part};
      end
    end
  end

  // Hand the word to the next cell; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_out.valid <= 1'b0;
    end else begin
      msg_out.valid <= msg_next.valid;
    end
    msg_out.first <= msg_next.first;
    msg_out.allow <= msg_next.allow;
    msg_out.hit   <= msg_next.hit;
    msg_out.after <= msg_next.after;
    msg_out.front <= msg_next.front;
    msg_out.pos   <= msg_next.pos;
    msg_out.gsum  <= msg_next.gsum;
  end

endmodule

/* sv/gmpq_resolve.sv */
// ----------------------------------------------------------------------------
// gmpq_resolve: final answer of a query
// Turns the word leaving the last cell into the gap flags, the ungapped
// position and the saturated row length.
// ----------------------------------------------------------------------------
module gmpq_resolve
  import gmpq_pkg::*;
(
  input  msg_t             msg,
  input  logic [POS_W-1:0] data_length,
  input  logic [ROW_W-1:0] total_gap,
  input  logic             table_used,
  output result_t          res
);

  logic [ROW_W:0]   row_sum;
  logic             tail;
  logic             gap;
  logic [SUM_W-1:0] pos_wide;

  always_comb begin
    row_sum  = {2'b00, data_length} + {1'b0, total_gap};
    // Column at or past the data plus every gap column
    tail     = {2'b00, msg.pos} >= row_sum;
    gap      = msg.hit || (!msg.after && tail);
    pos_wide = {{(SUM_W-POS_W){1'b0}}, msg.pos};

    res             = '0;
    res.status      = ST_ANSWER;
    res.is_gap      = gap;
    res.is_edge_gap = table_used && (msg.front || (!msg.after && tail));
    res.row_length  = row_sum[ROW_W] ? {ROW_W{1'b1}} : row_sum[ROW_W-1:0];
    if (gap && !msg.allow) begin
      res.pos_valid    = 1'b0;
      res.ungapped_pos = '0;
    end else begin
      res.pos_valid = 1'b1;
      if (msg.gsum > pos_wide) begin
        res.ungapped_pos = '0;
      end else begin
        res.ungapped_pos = msg.pos - msg.gsum[POS_W-1:0];
      end
    end
  end

endmodule

/* sv/gmpq_checker.sv */
// ----------------------------------------------------------------------------
// gmpq_checker: port-level checks for the gap model position query unit
// Watches the response channel for consistency of the answer fields.
// ----------------------------------------------------------------------------
module gmpq_checker
  import gmpq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input logic [1:0]       status,
  input logic             is_gap,
  input logic             is_edge_gap,
  input logic [POS_W-1:0] ungapped_pos,
  input logic             pos_valid,
  input logic [ROW_W-1:0] row_length
);

  // Reset drops any pending response word
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response word present after reset");

  // Stalled response word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(ungapped_pos) && $stable(row_length))
    else $error("stalled response word changed");

  // Non-query answers carry zero fields
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_ANSWER) |->
      !is_gap && !is_edge_gap && !pos_valid && (ungapped_pos == '0) &&
      (row_length == '0))
    else $error("non-query word carries answer fields");

  // An edge gap is a gap
  a_edge_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_edge_gap |-> is_gap)
    else $error("edge gap reported on a non-gap column");

  // An invalid position only comes from a gap column, and reads zero
  a_invalid_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_ANSWER) && !pos_valid |->
      is_gap && (ungapped_pos == '0))
    else $error("invalid position on a data column");

endmodule

bind gap_model_position_query_unit gmpq_checker u_gmpq_checker (.*);
